@@ src/cgf_pkg.sv @@
package cgf_pkg;

  // Sizes of the block
  localparam int MAX_ROWS    = 64;
  localparam int MAX_TAPS    = 8;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W     = $clog2(MAX_ROWS);
  localparam int LEN_W      = 7;
  localparam int COUNT_W    = 16;
  localparam int MODE_W     = 2;
  localparam int TAPS_W     = 4;
  localparam int COEF_W     = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int DIST_W     = $clog2(MAX_TAPS);
  localparam int STEP_W     = DIST_W + 1;
  localparam int POS_W      = LEN_W + 2;

  // Product and accumulator: up to 2*MAX_TAPS-1 products are summed
  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(2 * MAX_TAPS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_HIGH     = 3'd5;

  // Boundary modes; the spare code acts as zero padding
  localparam logic [MODE_W-1:0] MODE_ZERO     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REFLECT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd2;

  // Control travelling alongside one memory read into the MAC
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic zero;
  } mac_ctl_t;

endpackage

@@ src/cgf_ram.sv @@
module cgf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/cgf_mac.sv @@
module cgf_mac (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cgf_pkg::mac_ctl_t              ctl_i,
  input  logic [cgf_pkg::COEF_W-1:0]     coef_i,
  input  logic [cgf_pkg::SAMPLE_BITS-1:0] rd_data_i,
  output logic                           done_o,
  output logic [cgf_pkg::SAMPLE_BITS-1:0] smoothed_o
);
  import cgf_pkg::*;

  localparam logic [ACC_W:0]          ROUND_HALF = (ACC_W + 1)'(1) << (COEF_W - 1);
  localparam logic [ACC_W-COEF_W:0]   SAT_MAX    = (ACC_W - COEF_W + 1)'((1 << SAMPLE_BITS) - 1);

  mac_ctl_t            ctl2_r;
  logic [PROD_W-1:0]   prod_r;
  logic [ACC_W-1:0]    acc_r;
  logic                done_r;
  logic [ACC_W:0]      rounded;
  logic [ACC_W-COEF_W:0] scaled;

  // control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl2_r <= ctl_i;
      done_r <= ctl2_r.valid && ctl2_r.last;
    end
  end

  // multiply, then accumulate; a padded row contributes nothing
  always_ff @(posedge clk) begin
    prod_r <= ctl_i.zero ? '0 : PROD_W'(rd_data_i) * PROD_W'(coef_i);
    if (ctl2_r.valid) begin
      if (ctl2_r.first) begin
        acc_r <= ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  // round half up, drop the Q0.16 fraction, saturate
  assign rounded    = {1'b0, acc_r} + ROUND_HALF;
  assign scaled     = rounded[ACC_W:COEF_W];
  assign smoothed_o = (scaled > SAT_MAX) ? '1 : scaled[SAMPLE_BITS-1:0];
  assign done_o     = done_r;

endmodule

@@ src/column_gaussian_filter.sv @@
// Vertical symmetric Gaussian smoothing, one image column at a time.
// Input channel (in_valid/in_ready/in_sample): pixels of one column, top first,
// one word per cycle while the block is loading. in_ready is low while a
// column is being filtered.
// Result channel (out_*): one word per row once the column is complete, top
// first; out_column_end marks the last row, out_image_end also the last column.
// With reflect or periodic boundary mode and more taps than rows a single word with
// out_bad_config set and out_smoothed zero replaces the column.
// Configuration (cfg_we/cfg_index/cfg_data): one register per write, no wait.
// Timing: loading takes one cycle per sample while in_valid is held high. For each
// result the column store has one read port, so the 2*taps-1 reads of a row
// are issued one per cycle, followed by the multiply/accumulate drain and the
// load of the output register. The first word of a column follows this path
// after its last sample is taken, while an error word goes straight to the
// output register. Reset restores the register defaults and empties the load
// count and column index; the column store itself is not cleared. A stalled
// receiver holds the finished word in the output register; the next row is
// filtered but its word waits in ST_EMIT, while the last word of a column may
// wait as the next column loads.
module column_gaussian_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cgf_pkg::SAMPLE_BITS-1:0]   in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cgf_pkg::SAMPLE_BITS-1:0]   out_smoothed,
  output logic                              out_column_end,
  output logic                              out_image_end,
  output logic                              out_bad_config,
  input  logic                              cfg_we,
  input  logic [cgf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cgf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cgf_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // configuration registers
  logic [LEN_W-1:0]      cfg_length_r;
  logic [COUNT_W-1:0]    cfg_count_r;
  logic [MODE_W-1:0]     cfg_mode_r;
  logic [TAPS_W-1:0]     cfg_taps_r;
  logic [CFG_DATA_W-1:0] coef_low_r;
  logic [CFG_DATA_W-1:0] coef_high_r;

  // control state
  state_t                state_r;
  logic [ADDR_W-1:0]     loaded_r;
  logic [COUNT_W-1:0]    col_idx_r;
  logic [LEN_W-1:0]      n_r;
  logic [TAPS_W-1:0]     taps_r;
  logic [MODE_W-1:0]     mode_r;
  logic                  last_col_r;
  logic                  bad_r;
  logic [ADDR_W-1:0]     row_r;
  logic [STEP_W-1:0]     step_r;
  mac_ctl_t              ctl_s1_r;
  logic [COEF_W-1:0]     coef_s1_r;

  // output register
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_smoothed_r;
  logic                   out_column_end_r;
  logic                   out_image_end_r;
  logic                   out_bad_config_r;

  // clamped configuration
  logic [LEN_W-1:0]   n_eff;
  logic [TAPS_W-1:0]  taps_eff;
  logic [COUNT_W-1:0] cols_eff;
  logic [MODE_W-1:0]  mode_eff;

  logic               in_accept;
  logic [LEN_W-1:0]   count_next;
  logic               col_done;
  logic               last_col;
  logic               bad_col;

  logic [2*CFG_DATA_W-1:0] coef_all;
  logic [COEF_W-1:0]  coef_arr [MAX_TAPS];
  logic [DIST_W-1:0]  tap_dist;
  logic [STEP_W-1:0]  last_step;
  logic               step_last;
  logic signed [POS_W-1:0] pos;
  logic signed [POS_W-1:0] n_s;
  logic signed [POS_W-1:0] mapped;
  logic               pad_zero;
  logic               row_last;
  logic               out_free;

  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   mac_done;
  logic [SAMPLE_BITS-1:0] mac_smoothed;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_length_r <= LEN_W'(MAX_ROWS);
      cfg_count_r  <= COUNT_W'(1);
      cfg_mode_r   <= MODE_ZERO;
      cfg_taps_r   <= TAPS_W'(1);
      coef_low_r   <= CFG_DATA_W'(16'hFFFF);
      coef_high_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMN_LENGTH: cfg_length_r <= cfg_data[LEN_W-1:0];
        REG_COLUMN_COUNT:  cfg_count_r  <= cfg_data[COUNT_W-1:0];
        REG_BOUNDARY_MODE: cfg_mode_r   <= cfg_data[MODE_W-1:0];
        REG_TAP_COUNT:     cfg_taps_r   <= cfg_data[TAPS_W-1:0];
        REG_COEF_LOW:      coef_low_r   <= cfg_data;
        REG_COEF_HIGH:     coef_high_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp registers into their working ranges
  always_comb begin
    n_eff = cfg_length_r;
    if (cfg_length_r == '0) begin
      n_eff = LEN_W'(1);
    end else if (cfg_length_r > LEN_W'(MAX_ROWS)) begin
      n_eff = LEN_W'(MAX_ROWS);
    end
    taps_eff = cfg_taps_r;
    if (cfg_taps_r == '0) begin
      taps_eff = TAPS_W'(1);
    end else if (cfg_taps_r > TAPS_W'(MAX_TAPS)) begin
      taps_eff = TAPS_W'(MAX_TAPS);
    end
    cols_eff = (cfg_count_r == '0) ? COUNT_W'(1) : cfg_count_r;
    mode_eff = (cfg_mode_r == MODE_REFLECT || cfg_mode_r == MODE_PERIODIC) ?
               cfg_mode_r : MODE_ZERO;
  end

  // loading
  assign in_ready   = (state_r == ST_LOAD);
  assign in_accept  = in_valid && in_ready;
  assign count_next = LEN_W'(loaded_r) + LEN_W'(1);
  assign col_done   = (count_next >= n_eff);
  assign last_col   = ({1'b0, col_idx_r} + (COUNT_W + 1)'(1)) >= {1'b0, cols_eff};
  assign bad_col    = (mode_eff != MODE_ZERO) && (LEN_W'(taps_eff) > n_eff);

  // coefficient per tap distance
  assign coef_all = {coef_high_r, coef_low_r};

  always_comb begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      coef_arr[i] = coef_all[i*COEF_W +: COEF_W];
    end
  end

  // step k: 0 is the centre, odd k reads above, even k reads below
  assign tap_dist  = DIST_W'((STEP_W + 1)'(step_r) + (STEP_W + 1)'(1) >> 1);
  assign last_step = STEP_W'({taps_r, 1'b0} - (TAPS_W + 1)'(2));
  assign step_last = (step_r == last_step);
  assign n_s       = $signed(POS_W'(n_r));
  assign row_last  = (LEN_W'(row_r) == n_r - LEN_W'(1));

  // boundary mapping of the row to read
  always_comb begin
    pos = step_r[0] ? $signed(POS_W'(row_r)) - $signed(POS_W'(tap_dist)) :
                      $signed(POS_W'(row_r)) + $signed(POS_W'(tap_dist));
    mapped   = pos;
    pad_zero = 1'b0;
    if (pos < 0) begin
      if (mode_r == MODE_REFLECT) begin
        mapped = -pos;
      end else if (mode_r == MODE_PERIODIC) begin
        mapped = pos + n_s;
      end else begin
        pad_zero = 1'b1;
      end
    end else if (pos >= n_s) begin
      if (mode_r == MODE_REFLECT) begin
        mapped = (n_s <<< 1) - POS_W'(1) - pos;
      end else if (mode_r == MODE_PERIODIC) begin
        mapped = pos - n_s;
      end else begin
        pad_zero = 1'b1;
      end
    end
    if (mapped < 0 || mapped >= n_s) begin
      pad_zero = 1'b1;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      loaded_r    <= '0;
      col_idx_r   <= '0;
      n_r         <= LEN_W'(1);
      taps_r      <= TAPS_W'(1);
      mode_r      <= MODE_ZERO;
      last_col_r  <= 1'b0;
      bad_r       <= 1'b0;
      row_r       <= '0;
      step_r      <= '0;
      ctl_s1_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // MAC control is live only for reads issued this cycle
      ctl_s1_r.valid <= (state_r == ST_ISSUE);
      // output word: loaded from ST_EMIT, dropped once taken
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_accept) begin
            if (col_done) begin
              loaded_r   <= '0;
              n_r        <= n_eff;
              taps_r     <= taps_eff;
              mode_r     <= mode_eff;
              last_col_r <= last_col;
              bad_r      <= bad_col;
              col_idx_r  <= last_col ? '0 : col_idx_r + COUNT_W'(1);
              row_r      <= '0;
              step_r     <= '0;
              state_r    <= bad_col ? ST_EMIT : ST_ISSUE;
            end else begin
              loaded_r <= loaded_r + ADDR_W'(1);
            end
          end
        end
        ST_ISSUE: begin
          ctl_s1_r.first <= (step_r == '0);
          ctl_s1_r.last  <= step_last;
          ctl_s1_r.zero  <= pad_zero;
          step_r         <= step_r + STEP_W'(1);
          if (step_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (bad_r || row_last) begin
              state_r <= ST_LOAD;
            end else begin
              row_r   <= row_r + ADDR_W'(1);
              step_r  <= '0;
              state_r <= ST_ISSUE;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_ISSUE) begin
      coef_s1_r <= coef_arr[tap_dist];
    end
    if (state_r == ST_EMIT && out_free) begin
      out_smoothed_r   <= bad_r ? '0 : mac_smoothed;
      out_column_end_r <= bad_r || row_last;
      out_image_end_r  <= (bad_r || row_last) && last_col_r;
      out_bad_config_r <= bad_r;
    end
  end

  // column store: writes only while loading, reads only while filtering
  cgf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_ROWS)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_accept),
    .wr_addr (loaded_r),
    .wr_data (in_sample),
    .rd_en   (state_r == ST_ISSUE),
    .rd_addr (mapped[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  cgf_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl_s1_r),
    .coef_i     (coef_s1_r),
    .rd_data_i  (rd_data),
    .done_o     (mac_done),
    .smoothed_o (mac_smoothed)
  );

  assign out_valid      = out_valid_r;
  assign out_smoothed   = out_smoothed_r;
  assign out_column_end = out_column_end_r;
  assign out_image_end  = out_image_end_r;
  assign out_bad_config = out_bad_config_r;

endmodule

@@ dv/column_gaussian_filter_tb.sv @@
`timescale 1ns / 1ps

module column_gaussian_filter_tb;
  import cgf_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_WORDS  = 150;
  localparam int DIRECTED_ROWS = 46;

  // Codes the package leaves unnamed
  localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_profile_t;

  // One result word
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] smoothed;
    logic                   column_end;
    logic                   image_end;
    logic                   bad_config;
  } filt_word_t;

  // One row of the directed table: a register write or a pixel word
  typedef struct packed {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  pinned;
    filt_word_t            want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_sample = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] out_smoothed;
  logic                   out_column_end;
  logic                   out_image_end;
  logic                   out_bad_config;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  column_gaussian_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_smoothed(out_smoothed),
    .out_column_end(out_column_end), .out_image_end(out_image_end),
    .out_bad_config(out_bad_config),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the block: column store, load position and registers
  logic [SAMPLE_BITS-1:0] pixel_store [MAX_ROWS];
  int                     rows_loaded = 0;
  int                     col_pos = 0;
  logic [LEN_W-1:0]       shadow_len = 7'd64;
  logic [COUNT_W-1:0]     shadow_count = 16'd1;
  logic [MODE_W-1:0]      shadow_mode = MODE_ZERO;
  logic [TAPS_W-1:0]      shadow_taps = 4'd1;
  logic [CFG_DATA_W-1:0]  shadow_coef_lo = 64'd65535;
  logic [CFG_DATA_W-1:0]  shadow_coef_hi = 64'd0;

  filt_word_t expected_words [$];
  int         mismatches = 0;
  int         cycle_count = 0;
  int         send_gap_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_requests = 0;
  int         hold_served = 0;
  int         hold_left = 0;

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.idx = idx;
    row.value = val;
    return row;
  endfunction

  function automatic stim_row_t pixel_row(logic [SAMPLE_BITS-1:0] s);
    stim_row_t row;
    row = '0;
    row.value = CFG_DATA_W'(s);
    return row;
  endfunction

  // Pixel that ends a one-word column whose result is obvious
  function automatic stim_row_t pinned_row(logic [SAMPLE_BITS-1:0] s,
                                           logic [SAMPLE_BITS-1:0] sm, logic bad);
    stim_row_t row;
    row = pixel_row(s);
    row.pinned = 1'b1;
    row.want.smoothed = sm;
    row.want.column_end = 1'b1;
    row.want.image_end = 1'b1;
    row.want.bad_config = bad;
    return row;
  endfunction

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // one-row columns under the reset kernel
    reg_row(REG_COLUMN_LENGTH, 64'd1),
    pinned_row(16'h0000, 16'h0000, 1'b0),
    pixel_row(16'hFFFF),
    // more taps than rows with reflect and periodic: error word
    reg_row(REG_BOUNDARY_MODE, CFG_DATA_W'(MODE_REFLECT)),
    reg_row(REG_TAP_COUNT, 64'd2),
    pinned_row(16'h1234, 16'h0000, 1'b1),
    reg_row(REG_BOUNDARY_MODE, CFG_DATA_W'(MODE_PERIODIC)),
    pinned_row(16'hABCD, 16'h0000, 1'b1),
    // spare mode pads with zero
    reg_row(REG_BOUNDARY_MODE, CFG_DATA_W'(MODE_SPARE)),
    pixel_row(16'h8001),
    // out-of-range registers are clamped; unused index ignored
    reg_row(REG_TAP_COUNT, 64'd15),
    reg_row(REG_COLUMN_LENGTH, 64'd0),
    reg_row(REG_COLUMN_COUNT, 64'd0),
    reg_row(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF),
    pixel_row(16'h7FFE),
    // saturation, two columns per image
    reg_row(REG_COLUMN_LENGTH, 64'd3),
    reg_row(REG_BOUNDARY_MODE, CFG_DATA_W'(MODE_ZERO)),
    reg_row(REG_TAP_COUNT, 64'd3),
    reg_row(REG_COEF_LOW, 64'hFFFF_FFFF_FFFF_FFFF),
    reg_row(REG_COLUMN_COUNT, 64'd2),
    pixel_row(16'hFFFF), pixel_row(16'hFFFF), pixel_row(16'hFFFF),
    pixel_row(16'h0000), pixel_row(16'h0000), pixel_row(16'h0000),
    // reflect with the upper coefficient word in use
    reg_row(REG_COLUMN_LENGTH, 64'd5),
    reg_row(REG_BOUNDARY_MODE, CFG_DATA_W'(MODE_REFLECT)),
    reg_row(REG_TAP_COUNT, 64'd5),
    reg_row(REG_COEF_LOW, 64'h1000_2000_3000_4000),
    reg_row(REG_COEF_HIGH, 64'hFFFF_FFFF_FFFF_0800),
    reg_row(REG_COLUMN_COUNT, 64'd1),
    pixel_row(16'h0100), pixel_row(16'hF000), pixel_row(16'h0001),
    pixel_row(16'h8000), pixel_row(16'hFFFF),
    // periodic, then length lowered part way through a column
    reg_row(REG_COLUMN_LENGTH, 64'd6),
    reg_row(REG_BOUNDARY_MODE, CFG_DATA_W'(MODE_PERIODIC)),
    reg_row(REG_TAP_COUNT, 64'd2),
    reg_row(REG_COEF_LOW, 64'h0000_0000_4000_8000),
    pixel_row(16'h1111), pixel_row(16'h2222), pixel_row(16'h3333),
    reg_row(REG_COLUMN_LENGTH, 64'd2),
    pixel_row(16'h4444)
  };

  function automatic int effective_rows();
    int n;
    n = int'(shadow_len);
    if (n < 1) n = 1;
    if (n > MAX_ROWS) n = MAX_ROWS;
    return n;
  endfunction

  function automatic logic [COEF_W-1:0] kernel_tap(int d);
    if (d < 4) return shadow_coef_lo[16*d +: 16];
    return shadow_coef_hi[16*(d-4) +: 16];
  endfunction

  // Row fetch with the boundary rule applied
  function automatic logic [SAMPLE_BITS-1:0] row_at(int r, int n, logic [MODE_W-1:0] mode);
    if (r >= 0 && r < n) return pixel_store[r];
    if (mode == MODE_REFLECT) r = (r < 0) ? -r : (2 * n - 1 - r);
    else if (mode == MODE_PERIODIC) r = (r < 0) ? (r + n) : (r - n);
    else return '0;
    if (r < 0 || r >= n) return '0;
    return pixel_store[r];
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_COLUMN_LENGTH: shadow_len = val[LEN_W-1:0];
      REG_COLUMN_COUNT:  shadow_count = val[COUNT_W-1:0];
      REG_BOUNDARY_MODE: shadow_mode = val[MODE_W-1:0];
      REG_TAP_COUNT:     shadow_taps = val[TAPS_W-1:0];
      REG_COEF_LOW:      shadow_coef_lo = val;
      REG_COEF_HIGH:     shadow_coef_hi = val;
      default: ;
    endcase
  endfunction

  // Store one pixel; a completed column queues its smoothed rows
  task automatic absorb_pixel(input logic [SAMPLE_BITS-1:0] s);
    int               n, taps, cols;
    logic [MODE_W-1:0] mode;
    logic             last_col;
    logic [39:0]      acc;
    logic [16:0]      pair;
    filt_word_t       w;
    n = effective_rows();
    taps = int'(shadow_taps);
    if (taps < 1) taps = 1;
    if (taps > MAX_TAPS) taps = MAX_TAPS;
    cols = (shadow_count == 0) ? 1 : int'(shadow_count);
    mode = (shadow_mode == MODE_SPARE) ? MODE_ZERO : shadow_mode;
    if (rows_loaded < MAX_ROWS) pixel_store[rows_loaded] = s;
    rows_loaded++;
    if (rows_loaded < n) return;
    rows_loaded = 0;
    last_col = (col_pos + 1 >= cols);
    if (mode != MODE_ZERO && taps > n) begin
      w.smoothed = '0;
      w.column_end = 1'b1;
      w.image_end = last_col;
      w.bad_config = 1'b1;
      expected_words.push_back(w);
    end else begin
      for (int r = 0; r < n; r++) begin
        acc = 40'(kernel_tap(0)) * 40'(pixel_store[r]);
        for (int d = 1; d < taps; d++) begin
          pair = 17'(row_at(r - d, n, mode)) + 17'(row_at(r + d, n, mode));
          acc += 40'(kernel_tap(d)) * 40'(pair);
        end
        acc = (acc + 40'd32768) >> 16;
        w.smoothed = (acc > 40'd65535) ? 16'hFFFF : acc[15:0];
        w.column_end = (r == n - 1);
        w.image_end = (r == n - 1) && last_col;
        w.bad_config = 1'b0;
        expected_words.push_back(w);
      end
    end
    col_pos = last_col ? 0 : ((col_pos + 1) & 16'hFFFF);
  endtask

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (mismatches < 100)
      $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one pixel word, optionally after a gap, and return once taken
  task automatic send_pixel(input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_gap_pct) gap++;
    cfg_we <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    absorb_pixel(s);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  // Block idle: results all in and the last row's pipeline flushed
  task automatic wait_until_quiet();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_pixel();
    case ($urandom_range(3))
      0, 1: return SAMPLE_BITS'($urandom_range(65535));
      2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return SAMPLE_BITS'($urandom_range(255));
    endcase
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("column_gaussian_filter_tb: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin
    filt_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word", out_smoothed, 16'h0000);
      end else begin
        w = expected_words.pop_front();
        if (out_smoothed !== w.smoothed)
          note_mismatch("smoothed", out_smoothed, w.smoothed);
        if (out_column_end !== w.column_end)
          note_mismatch("column_end", 16'(out_column_end), 16'(w.column_end));
        if (out_image_end !== w.image_end)
          note_mismatch("image_end", 16'(out_image_end), 16'(w.image_end));
        if (out_bad_config !== w.bad_config)
          note_mismatch("bad_config", 16'(out_bad_config), 16'(w.bad_config));
      end
    end
  end

  initial begin
    int                    random_words;
    int                    phase;
    int                    n;
    int                    cols;
    int                    taps_max;
    int                    len_pick;
    logic [CFG_DATA_W-1:0] new_len;
    logic [CFG_DATA_W-1:0] new_count;
    logic [CFG_DATA_W-1:0] new_taps;
    logic [127:0]          kernel;
    idle_profile_t         profile;
    logic                  prev_reg;
    random_words = 0;
    phase = 0;
    prev_reg = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].is_reg) begin
        if (!prev_reg) wait_until_quiet();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_pixel(directed_rows[i].value[SAMPLE_BITS-1:0]);
        if (directed_rows[i].pinned) begin
          void'(expected_words.pop_back());
          expected_words.push_back(directed_rows[i].want);
        end
      end
      prev_reg = directed_rows[i].is_reg;
    end

    // Random phases: fresh registers, then whole columns of random pixels
    while (random_words < RANDOM_WORDS || phase < 4) begin
      profile = idle_profile_t'(phase % 4);
      case (profile)
        IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct <= 0;  end
        IDLE_SENDER:   begin send_gap_pct = 63; recv_stall_pct <= 0;  end
        IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct <= 63; end
        default:       begin send_gap_pct = 28; recv_stall_pct <= 28; end
      endcase
      wait_until_quiet();

      len_pick = $urandom_range(99);
      if (phase == 2) new_len = CFG_DATA_W'(4);
      else if (len_pick < 3) new_len = '0;
      else if (len_pick < 75) new_len = CFG_DATA_W'($urandom_range(10, 1));
      else if (len_pick < 90) new_len = CFG_DATA_W'($urandom_range(40, 11));
      else if (len_pick < 95) new_len = CFG_DATA_W'(64);
      else new_len = CFG_DATA_W'($urandom_range(127, 65));
      write_reg(REG_COLUMN_LENGTH, new_len);
      n = effective_rows();

      case ($urandom_range(5))
        0: new_count = '0;
        1: new_count = CFG_DATA_W'(65535);
        default: new_count = CFG_DATA_W'($urandom_range(5, 1));
      endcase
      write_reg(REG_COLUMN_COUNT, new_count);
      write_reg(REG_BOUNDARY_MODE, CFG_DATA_W'($urandom_range(3)));

      taps_max = (n < MAX_TAPS) ? n : MAX_TAPS;
      if ($urandom_range(99) < 80) new_taps = CFG_DATA_W'($urandom_range(taps_max, 1));
      else new_taps = CFG_DATA_W'($urandom_range(15));
      write_reg(REG_TAP_COUNT, new_taps);

      // Kernel: wholly random, roughly normalised, all ones in the low word, or random in the low word only
      case ($urandom_range(3))
        0: kernel = {$urandom, $urandom, $urandom, $urandom};
        1: begin
          for (int t = 0; t < MAX_TAPS; t++)
            kernel[16*t +: 16] = 16'($urandom_range(65535 / (2 * new_taps + 1)));
        end
        2: kernel = {64'($urandom_range(1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0),
                     64'hFFFF_FFFF_FFFF_FFFF};
        default: kernel = {64'h0, $urandom, $urandom};
      endcase
      write_reg(REG_COEF_LOW, kernel[63:0]);
      write_reg(REG_COEF_HIGH, kernel[127:64]);

      cols = (n > 16) ? 1 : $urandom_range(4, 1);
      // Long receiver hold-off while several columns queue up behind it
      if (phase == 2) begin
        hold_requests <= hold_requests + 1;
        cols = 4;
      end

      for (int c = 0; c < cols; c++) begin
        if (phase == 3 && c != 0) drain_results();
        for (int i = 0; i < n; i++) begin
          send_pixel(pick_pixel());
          random_words++;
        end
      end

      // Now and then leave a column part loaded
      if (n > 1 && $urandom_range(99) < 15) begin
        for (int i = $urandom_range(n - 1, 1); i > 0; i--) begin
          send_pixel(pick_pixel());
          random_words++;
        end
      end
      phase++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("column_gaussian_filter_tb: PASS");
    end else begin
      $display("column_gaussian_filter_tb: FAIL");
    end
    $finish;
  end

endmodule
